// ===== hw/rtl/cbb_pkg.sv =====
// Shared types and constants for the cubic Bezier bounding box pipeline.
`timescale 1ns / 1ps

package cbb_pkg;

    localparam int COORD_BITS  = 24;
    localparam int T_FRAC_BITS = 16;
    localparam int EVAL_STAGES = 6;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t handle1_x;
        coord_t handle1_y;
        coord_t handle2_x;
        coord_t handle2_y;
        coord_t end_x;
        coord_t end_y;
    } cbb_in_t;

    typedef struct packed {
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_max_x;
        coord_t box_max_y;
    } cbb_out_t;

    // difference, product, discriminant, square root, root select,
    // divider, curve evaluation and box update
    function automatic int cbb_latency(input int frac_bits);
        return 3 + (COORD_BITS + 2) + 1 + (frac_bits + 2) + EVAL_STAGES + 1;
    endfunction

endpackage

// ===== hw/rtl/cbb_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module cbb_isqrt #(
    parameter int RW = 26,
    parameter int SW = 8
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] h,
    input  logic [SW-1:0]   side_in,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   side_out
);

    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] hs_reg   [RW];
    logic [SW-1:0]   side_reg [RW];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic [RW+1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [2*RW-1:0] hs_in;
        logic [SW-1:0]   side_in_st;
        logic [RW+3:0]   rem_sh;
        logic [RW+3:0]   trial;
        logic [RW+3:0]   rem_dif;
        logic            fit;

        if (i == 0) begin : g_first
            assign rem_in     = '0;
            assign root_in    = '0;
            assign hs_in      = h;
            assign side_in_st = side_in;
        end else begin : g_rest
            assign rem_in     = rem_reg[i-1];
            assign root_in    = root_reg[i-1];
            assign hs_in      = hs_reg[i-1];
            assign side_in_st = side_reg[i-1];
        end

        assign rem_sh  = {rem_in, hs_in[2*RW-1 -: 2]};
        assign trial   = {2'b00, root_in, 2'b01};
        assign fit     = rem_sh >= trial;
        assign rem_dif = rem_sh - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= fit ? rem_dif[RW+1:0] : rem_sh[RW+1:0];
                root_reg[i] <= {root_in[RW-2:0], fit};
                hs_reg[i]   <= {hs_in[2*RW-3:0], 2'b00};
                side_reg[i] <= side_in_st;
            end
        end
    end

    assign root     = root_reg[RW-1];
    assign side_out = side_reg[RW-1];

endmodule

// ===== hw/rtl/cbb_div.sv =====
// Pipelined rounded divider for the root parameter t, one quotient bit per stage.
`timescale 1ns / 1ps

module cbb_div #(
    parameter int AW = 27,
    parameter int FB = 16,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic [AW-1:0] un,
    input  logic [AW-1:0] ua,
    input  logic [SW-1:0] side_in,
    output logic [FB:0]   quo,
    output logic [SW-1:0] side_out
);

    localparam int XW = AW + FB + 1;

    logic [XW-1:0] x_next;

    logic [AW-1:0] r_reg    [FB+2];
    logic [FB:0]   l_reg    [FB+2];
    logic [AW-1:0] ua_reg   [FB+2];
    logic [SW-1:0] side_reg [FB+2];
    logic [FB:0]   q_reg    [FB+1];

    // numerator is un * 2^FB plus half the divisor, so the quotient rounds
    assign x_next = {1'b0, un, {FB{1'b0}}} + XW'(ua >> 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= x_next[XW-1:FB+1];
            l_reg[0]    <= x_next[FB:0];
            ua_reg[0]   <= ua;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 1; i <= FB + 1; i++) begin : g_stage
        logic [FB:0] q_prev;
        logic [AW:0] r_sh;
        logic [AW:0] r_dif;
        logic        fit;

        if (i == 1) begin : g_first
            assign q_prev = '0;
        end else begin : g_rest
            assign q_prev = q_reg[i-2];
        end

        assign r_sh  = {r_reg[i-1], l_reg[i-1][FB]};
        assign fit   = r_sh >= {1'b0, ua_reg[i-1]};
        assign r_dif = r_sh - {1'b0, ua_reg[i-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i]    <= fit ? r_dif[AW-1:0] : r_sh[AW-1:0];
                l_reg[i]    <= {l_reg[i-1][FB-1:0], 1'b0};
                ua_reg[i]   <= ua_reg[i-1];
                side_reg[i] <= side_reg[i-1];
                q_reg[i-1]  <= {q_prev[FB-1:0], fit};
            end
        end
    end

    assign quo      = q_reg[FB];
    assign side_out = side_reg[FB+1];

endmodule

// ===== hw/rtl/cbb_eval.sv =====
// Pipelined Horner evaluation of one curve axis at a Q1.F parameter.
`timescale 1ns / 1ps

module cbb_eval #(
    parameter int F  = 16,
    parameter int SW = 8
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [F:0]                           t,
    input  cbb_pkg::coord_t                      p0,
    input  logic signed [cbb_pkg::COORD_BITS:0]  c,
    input  logic signed [cbb_pkg::COORD_BITS+1:0] b,
    input  logic signed [cbb_pkg::COORD_BITS+2:0] a,
    input  logic [SW-1:0]                        side_in,
    output cbb_pkg::coord_t                      v,
    output logic [SW-1:0]                        side_out
);

    import cbb_pkg::*;

    localparam int N   = COORD_BITS;
    localparam int M1W = N + F + 5;
    localparam int M2W = M1W + F + 2;
    localparam int U2W = N + 2 * F + 5;
    localparam int M3W = U2W + F + 2;

    logic signed [F+1:0]  ts;
    logic signed [M1W-1:0] m1_next, u1_next, b3;
    logic signed [M2W-1:0] m2_next, u2_wide, c3;
    logic signed [U2W-1:0] u2_next;
    logic signed [M3W-1:0] m3_next, sum_e6;

    logic signed [M1W-1:0] m1_reg, u1_reg;
    logic signed [M2W-1:0] m2_reg;
    logic signed [U2W-1:0] u2_reg;
    logic signed [M3W-1:0] m3_reg;
    coord_t                v_reg;
    logic [F:0]            t1_reg, t2_reg, t3_reg, t4_reg;
    coord_t                p0_1_reg, p0_2_reg, p0_3_reg, p0_4_reg, p0_5_reg;
    logic signed [N:0]     c_1_reg, c_2_reg, c_3_reg;
    logic signed [N+1:0]   b_1_reg;
    logic [SW-1:0]         side_reg [EVAL_STAGES];

    // stage 1: a*t
    assign ts      = $signed({1'b0, t});
    assign m1_next = M1W'(a) * M1W'(ts);

    // stage 2: add 3b
    assign b3      = M1W'(b_1_reg) + (M1W'(b_1_reg) <<< 1);
    assign u1_next = m1_reg + (b3 <<< F);

    // stage 3: times t
    assign m2_next = M2W'(u1_reg) * M2W'($signed({1'b0, t2_reg}));

    // stage 4: add 3c
    assign c3      = M2W'(c_3_reg) + (M2W'(c_3_reg) <<< 1);
    assign u2_wide = m2_reg + (c3 <<< (2 * F));
    assign u2_next = u2_wide[U2W-1:0];

    // stage 5: times t
    assign m3_next = M3W'(u2_reg) * M3W'($signed({1'b0, t4_reg}));

    // stage 6: add p0, round to nearest
    assign sum_e6 = m3_reg + (M3W'(p0_5_reg) <<< (3 * F))
                  + (M3W'(1'b1) <<< (3 * F - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg   <= m1_next;
            t1_reg   <= t;
            p0_1_reg <= p0;
            c_1_reg  <= c;
            b_1_reg  <= b;

            u1_reg   <= u1_next;
            t2_reg   <= t1_reg;
            p0_2_reg <= p0_1_reg;
            c_2_reg  <= c_1_reg;

            m2_reg   <= m2_next;
            t3_reg   <= t2_reg;
            p0_3_reg <= p0_2_reg;
            c_3_reg  <= c_2_reg;

            u2_reg   <= u2_next;
            t4_reg   <= t3_reg;
            p0_4_reg <= p0_3_reg;

            m3_reg   <= m3_next;
            p0_5_reg <= p0_4_reg;

            v_reg    <= sum_e6[3*F+N-1:3*F];

            side_reg[0] <= side_in;
            for (int i = 1; i < EVAL_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign v        = v_reg;
    assign side_out = side_reg[EVAL_STAGES-1];

endmodule

// ===== hw/rtl/cbb_axis.sv =====
// One axis of the bounding box: differences, discriminant, roots and extremes.
`timescale 1ns / 1ps

module cbb_axis #(
    parameter int F = 16
) (
    input  logic            clk,
    input  logic            en,
    input  cbb_pkg::coord_t p0,
    input  cbb_pkg::coord_t p1,
    input  cbb_pkg::coord_t p2,
    input  cbb_pkg::coord_t p3,
    output cbb_pkg::coord_t mn,
    output cbb_pkg::coord_t mx
);

    import cbb_pkg::*;

    localparam int N   = COORD_BITS;
    localparam int RW  = N + 2;
    localparam int HW  = 2 * RW;
    localparam int AW  = N + 3;
    localparam int NW  = N + 4;
    localparam int PW  = 2 * N + 4;
    localparam int SW1 = 6 * N + 7;
    localparam int SW2 = 6 * N + 7;
    localparam int SW3 = 2 * N + 1;

    // stage 1
    logic signed [N:0]   c_next;
    logic signed [N+1:0] b_next;
    logic signed [N+2:0] d12, a_next;
    logic signed [N:0]   c1_reg;
    logic signed [N+1:0] b1_reg;
    logic signed [N+2:0] a1_reg;
    coord_t              p0_1_reg, mn1_reg, mx1_reg;

    assign c_next = (N+1)'(p1) - (N+1)'(p0);
    assign b_next = (N+2)'(p0) - ((N+2)'(p1) <<< 1) + (N+2)'(p2);
    assign d12    = (N+3)'(p1) - (N+3)'(p2);
    assign a_next = (N+3)'(p3) - (N+3)'(p0) + d12 + (d12 <<< 1);

    // stage 2
    logic signed [PW-1:0] bb_reg, ac_reg;
    logic signed [N:0]    c2_reg;
    logic signed [N+1:0]  b2_reg;
    logic signed [N+2:0]  a2_reg;
    coord_t               p0_2_reg, mn2_reg, mx2_reg;

    // stage 3
    logic signed [PW:0]  h_wide;
    logic                use_next;
    logic [HW-1:0]       h3_reg;
    logic                use3_reg;
    logic signed [N:0]   c3_reg;
    logic signed [N+1:0] b3_reg;
    logic signed [N+2:0] a3_reg;
    coord_t              p0_3_reg, mn3_reg, mx3_reg;

    assign h_wide   = (PW+1)'(bb_reg) - (PW+1)'(ac_reg);
    assign use_next = !h_wide[PW] && (h_wide != '0) && (a2_reg != '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= c_next;
            b1_reg   <= b_next;
            a1_reg   <= a_next;
            p0_1_reg <= p0;
            mn1_reg  <= (p0 < p3) ? p0 : p3;
            mx1_reg  <= (p0 < p3) ? p3 : p0;

            bb_reg   <= PW'(b1_reg) * PW'(b1_reg);
            ac_reg   <= PW'(a1_reg) * PW'(c1_reg);
            c2_reg   <= c1_reg;
            b2_reg   <= b1_reg;
            a2_reg   <= a1_reg;
            p0_2_reg <= p0_1_reg;
            mn2_reg  <= mn1_reg;
            mx2_reg  <= mx1_reg;

            h3_reg   <= use_next ? h_wide[HW-1:0] : '0;
            use3_reg <= use_next;
            c3_reg   <= c2_reg;
            b3_reg   <= b2_reg;
            a3_reg   <= a2_reg;
            p0_3_reg <= p0_2_reg;
            mn3_reg  <= mn2_reg;
            mx3_reg  <= mx2_reg;
        end
    end

    // square root
    logic [RW-1:0]       root;
    logic [SW1-1:0]      sq_side;
    logic                use_q;
    logic signed [N+2:0] a_q;
    logic signed [N+1:0] b_q;
    logic signed [N:0]   c_q;
    coord_t              p0_q, mn_q, mx_q;

    cbb_isqrt #(
        .RW (RW),
        .SW (SW1)
    ) u_isqrt (
        .clk      (clk),
        .en       (en),
        .h        (h3_reg),
        .side_in  ({use3_reg, a3_reg, b3_reg, c3_reg, p0_3_reg, mn3_reg, mx3_reg}),
        .root     (root),
        .side_out (sq_side)
    );

    assign {use_q, a_q, b_q, c_q, p0_q, mn_q, mx_q} = sq_side;

    // stage 4: pick the roots inside the open interval
    logic signed [NW-1:0] rs, nb, num0, num1, an, abs0, abs1;
    logic                 apos, in0_next, in1_next;
    logic [AW-1:0]        ua_next;

    assign rs   = $signed({2'b00, root});
    assign nb   = -NW'(b_q);
    assign num0 = nb - rs;
    assign num1 = nb + rs;
    assign an   = NW'(a_q);
    assign apos = !a_q[N+2];
    assign abs0 = num0[NW-1] ? -num0 : num0;
    assign abs1 = num1[NW-1] ? -num1 : num1;

    assign in0_next = use_q && (apos ? (num0 > 0 && num0 < an) : (num0 < 0 && num0 > an));
    assign in1_next = use_q && (apos ? (num1 > 0 && num1 < an) : (num1 < 0 && num1 > an));
    assign ua_next  = apos ? a_q[AW-1:0] : AW'(-a_q);

    logic [AW-1:0]       un0_reg, un1_reg, ua4_reg;
    logic                in0_4_reg, in1_4_reg;
    logic signed [N+2:0] a4_reg;
    logic signed [N+1:0] b4_reg;
    logic signed [N:0]   c4_reg;
    coord_t              p0_4_reg, mn4_reg, mx4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            un0_reg   <= in0_next ? abs0[AW-1:0] : '0;
            un1_reg   <= in1_next ? abs1[AW-1:0] : '0;
            ua4_reg   <= ua_next;
            in0_4_reg <= in0_next;
            in1_4_reg <= in1_next;
            a4_reg    <= a_q;
            b4_reg    <= b_q;
            c4_reg    <= c_q;
            p0_4_reg  <= p0_q;
            mn4_reg   <= mn_q;
            mx4_reg   <= mx_q;
        end
    end

    // divide for t on both roots
    logic [F:0]          t0, t1;
    logic [SW2-1:0]      dv_side;
    logic                in0_d, in1_d;
    logic signed [N+2:0] a_d;
    logic signed [N+1:0] b_d;
    logic signed [N:0]   c_d;
    coord_t              p0_d, mn_d, mx_d;

    cbb_div #(
        .AW (AW),
        .FB (F),
        .SW (SW2)
    ) u_div0 (
        .clk      (clk),
        .en       (en),
        .un       (un0_reg),
        .ua       (ua4_reg),
        .side_in  ({in0_4_reg, a4_reg, b4_reg, c4_reg, p0_4_reg, mn4_reg, mx4_reg}),
        .quo      (t0),
        .side_out (dv_side)
    );

    cbb_div #(
        .AW (AW),
        .FB (F),
        .SW (1)
    ) u_div1 (
        .clk      (clk),
        .en       (en),
        .un       (un1_reg),
        .ua       (ua4_reg),
        .side_in  (in1_4_reg),
        .quo      (t1),
        .side_out (in1_d)
    );

    assign {in0_d, a_d, b_d, c_d, p0_d, mn_d, mx_d} = dv_side;

    // evaluate the curve at both roots
    coord_t         v0, v1;
    logic [SW3-1:0] ev_side;
    logic           in0_e, in1_e;
    coord_t         mn_e, mx_e;

    cbb_eval #(
        .F  (F),
        .SW (SW3)
    ) u_eval0 (
        .clk      (clk),
        .en       (en),
        .t        (t0),
        .p0       (p0_d),
        .c        (c_d),
        .b        (b_d),
        .a        (a_d),
        .side_in  ({in0_d, mn_d, mx_d}),
        .v        (v0),
        .side_out (ev_side)
    );

    cbb_eval #(
        .F  (F),
        .SW (1)
    ) u_eval1 (
        .clk      (clk),
        .en       (en),
        .t        (t1),
        .p0       (p0_d),
        .c        (c_d),
        .b        (b_d),
        .a        (a_d),
        .side_in  (in1_d),
        .v        (v1),
        .side_out (in1_e)
    );

    assign {in0_e, mn_e, mx_e} = ev_side;

    // widen the box
    coord_t mn_a, mx_a, mn_next, mx_next;
    coord_t mn_reg, mx_reg;

    assign mn_a    = (in0_e && v0 < mn_e) ? v0 : mn_e;
    assign mx_a    = (in0_e && v0 > mx_e) ? v0 : mx_e;
    assign mn_next = (in1_e && v1 < mn_a) ? v1 : mn_a;
    assign mx_next = (in1_e && v1 > mx_a) ? v1 : mx_a;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mn_reg <= mn_next;
            mx_reg <= mx_next;
        end
    end

    assign mn = mn_reg;
    assign mx = mx_reg;

endmodule

// ===== hw/rtl/cubic_bezier_bounding_box.sv =====
// Top level: tight bounding box of a 2D cubic Bezier curve, fully pipelined.
//
//  channel | direction | word      | handshake
//  --------+-----------+-----------+------------------------
//  in      | into      | cbb_in_t  | in_valid / in_ready
//  out     | out of    | cbb_out_t | out_valid / out_ready
//
// One word enters per cycle while in_ready is high; the square root and
// divider pipelines produce one result bit per stage. Reset clears only
// the valid bits. When out holds a word that is not taken, every stage
// holds and in_ready drops.
`timescale 1ns / 1ps

module cubic_bezier_bounding_box #(
    parameter int T_FRAC_BITS = cbb_pkg::T_FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cbb_pkg::cbb_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cbb_pkg::cbb_out_t out_data
);

    import cbb_pkg::*;

    localparam int LAT = cbb_latency(T_FRAC_BITS);

    logic           en;
    logic [LAT-1:0] vld_reg, vld_next;

    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    cbb_axis #(
        .F (T_FRAC_BITS)
    ) u_axis_x (
        .clk (clk),
        .en  (en),
        .p0  (in_data.start_x),
        .p1  (in_data.handle1_x),
        .p2  (in_data.handle2_x),
        .p3  (in_data.end_x),
        .mn  (out_data.box_min_x),
        .mx  (out_data.box_max_x)
    );

    cbb_axis #(
        .F (T_FRAC_BITS)
    ) u_axis_y (
        .clk (clk),
        .en  (en),
        .p0  (in_data.start_y),
        .p1  (in_data.handle1_y),
        .p2  (in_data.handle2_y),
        .p3  (in_data.end_y),
        .mn  (out_data.box_min_y),
        .mx  (out_data.box_max_y)
    );

    assign out_valid = vld_reg[LAT-1];

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without a stalled output word");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted word did not enter the pipeline");

    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.box_min_x <= out_data.box_max_x
                       && out_data.box_min_y <= out_data.box_max_y))
        else $error("box minimum above maximum");

endmodule
